### rtl/core/waveform_column_plotter_macros.svh
// Assertion macros for the waveform column plotter.
`ifndef WAVEFORM_COLUMN_PLOTTER_MACROS_SVH
`define WAVEFORM_COLUMN_PLOTTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/wcp_pkg.sv
// Types and constants for the waveform column plotter.
`default_nettype none
package wcp_pkg;

  localparam int DIV_W = 25;
  localparam int REM_W = 17;
  localparam int CNT_W = 5;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    REG_X_START     = 3'd0,
    REG_Y_START     = 3'd1,
    REG_PLOT_WIDTH  = 3'd2,
    REG_PLOT_HEIGHT = 3'd3,
    REG_MAX_VALUE   = 3'd4,
    REG_GAIN        = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        action;
    logic [15:0] sample;
    logic        last_sample;
  } item_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] span_top;
    logic [7:0] span_bottom;
    logic       on_screen;
    logic       final_column;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLOSE1,
    ST_CLOSE2,
    ST_IDX,
    ST_DIV,
    ST_READ,
    ST_SCALE1,
    ST_SCALE2,
    ST_SCALE3,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

### rtl/core/waveform_column_plotter.sv
// Waveform column plotter: sample store, autoscale and serial column mapping.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  item    | in        | start & !busy        | item (action/sample/last)
//  result  | out       | done, one cycle      | result (column/span/flags)
//  config  | in        | cfg_we               | cfg_index, cfg_data
//
// A load beat runs ST_LOAD, and ST_CLOSE1 and ST_CLOSE2 too when it closes the set
// (range and pad math). A draw beat that yields a span, when the samples outnumber
// the plot columns, makes two passes through the shared radix-2 restoring divider,
// one for the sample index and one for the row. With a direct column-to-sample map
// it makes only the row pass. In fixed gain with a zero full scale the row pass is
// skipped. A draw beat with nothing to draw stays in idle and yields no result.
// Reset clears all control state; the sample store is not cleared.
// Results cannot be stalled: done pulses for one cycle with result valid.
`default_nettype none
module waveform_column_plotter import wcp_pkg::*; #(
  parameter int MAX_SAMPLES    = 256,
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  `include "waveform_column_plotter_macros.svh"

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int NW = $clog2(MAX_SAMPLES + 1);

  // Configuration registers.
  logic [7:0]  x_start, y_start, plot_width, plot_height, gain;
  logic [15:0] max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start     <= 8'd0;
      y_start     <= 8'd0;
      plot_width  <= 8'd128;
      plot_height <= 8'd64;
      max_value   <= 16'd4095;
      gain        <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_START:     x_start     <= cfg_data[7:0];
        REG_Y_START:     y_start     <= cfg_data[7:0];
        REG_PLOT_WIDTH:  plot_width  <= cfg_data[7:0];
        REG_PLOT_HEIGHT: plot_height <= cfg_data[7:0];
        REG_MAX_VALUE:   max_value   <= cfg_data;
        REG_GAIN:        gain        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sample store, registered read.
  logic [15:0] store [MAX_SAMPLES];
  logic [15:0] rdata;
  logic        store_we;
  logic [AW-1:0] store_waddr, idx;
  item_t  item_r;

  always_ff @(posedge clk) begin
    if (store_we) store[store_waddr] <= item_r.sample;
    rdata <= store[idx];
  end

  // Control and datapath state.
  state_t state, state_next;
  logic [NW-1:0] sample_total;
  logic [15:0]   run_min, run_max, disp_min, range_r;
  logic [16:0]   pad;
  logic [7:0]    col_cnt, prev_row;
  logic          have_prev, loading, set_ready;
  logic          sel_row, zero_fs;

  // Shared divider.
  logic [DIV_W-1:0] qsh;
  logic [REM_W-1:0] rem, den;
  logic [CNT_W-1:0] div_cnt;
  logic [REM_W:0]   rem_sh;
  logic             rem_ge;

  assign rem_sh = {rem, qsh[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den};

  logic draw_ok, first, full, wide;
  logic [15:0] new_min, new_max;
  logic [DIV_W-1:0] acc;
  logic [15:0] half_pad;

  assign draw_ok = set_ready && (plot_width != 8'd0) && (plot_height != 8'd0) &&
                   (sample_total != '0) && (col_cnt < plot_width);
  assign first   = !loading;
  assign full    = !first && (sample_total >= NW'(MAX_SAMPLES));
  assign wide    = 9'(sample_total) > {1'b0, plot_width};
  assign half_pad = (16'(range_r[15:2]) + 16'd4) >> 1;

  always_comb begin
    new_min = first ? item_r.sample : run_min;
    new_max = first ? item_r.sample : run_max;
    if (!full) begin
      if (item_r.sample < new_min) new_min = item_r.sample;
      if (item_r.sample > new_max) new_max = item_r.sample;
    end
  end

  assign store_we    = (state == ST_LOAD) && !full;
  assign store_waddr = first ? '0 : sample_total[AW-1:0];
  assign busy        = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (item.action == ACT_LOAD) state_next = ST_LOAD;
          else if (draw_ok)            state_next = ST_IDX;
        end
      end
      ST_LOAD:   state_next = item_r.last_sample ? ST_CLOSE1 : ST_IDLE;
      ST_CLOSE1: state_next = ST_CLOSE2;
      ST_CLOSE2: state_next = ST_IDLE;
      ST_IDX:    state_next = wide ? ST_DIV : ST_READ;
      ST_DIV: begin
        if (div_cnt == '0) state_next = sel_row ? ST_FIN : ST_READ;
      end
      ST_READ:   state_next = ST_SCALE1;
      ST_SCALE1: state_next = ST_SCALE2;
      ST_SCALE2: state_next = ST_SCALE3;
      ST_SCALE3: state_next = (gain != 8'd0 && max_value == 16'd0) ? ST_FIN : ST_DIV;
      ST_FIN:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Row math for the final step.
  logic [7:0] base_row, cur_row, top_row, bot_row, col_pos;
  assign base_row = y_start + plot_height - 8'd1;
  assign cur_row  = zero_fs ? y_start : base_row - qsh[7:0];
  assign top_row  = (have_prev && prev_row < cur_row) ? prev_row : cur_row;
  assign bot_row  = (have_prev && prev_row > cur_row) ? prev_row : cur_row;
  assign col_pos  = x_start + col_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total <= '0;
      run_min      <= 16'd0;
      run_max      <= 16'd0;
      pad          <= 17'd1;
      disp_min     <= 16'd0;
      col_cnt      <= 8'd0;
      prev_row     <= 8'd0;
      have_prev    <= 1'b0;
      loading      <= 1'b0;
      set_ready    <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) item_r <= item;
        end
        ST_LOAD: begin
          if (first) begin
            loading   <= 1'b1;
            set_ready <= 1'b0;
            col_cnt   <= 8'd0;
            have_prev <= 1'b0;
          end
          run_min <= new_min;
          run_max <= new_max;
          if (!full) sample_total <= first ? NW'(1) : sample_total + NW'(1);
        end
        ST_CLOSE1: begin
          range_r <= (run_max == run_min) ? 16'd1 : run_max - run_min;
        end
        ST_CLOSE2: begin
          // pad = range + range/4 + 4; shift the minimum down by half the margin
          pad <= 17'(range_r) + 17'(range_r[15:2]) + 17'd4;
          disp_min <= (run_min > half_pad) ? run_min - half_pad : 16'd0;
          set_ready <= 1'b1;
          loading   <= 1'b0;
          col_cnt   <= 8'd0;
          have_prev <= 1'b0;
        end
        ST_IDX: begin
          sel_row <= 1'b0;
          zero_fs <= 1'b0;
          if (wide) begin
            qsh     <= DIV_W'(col_cnt) * DIV_W'(sample_total);
            den     <= REM_W'(plot_width);
            rem     <= '0;
            div_cnt <= CNT_W'(DIV_W - 1);
          end else begin
            idx <= (9'(col_cnt) < 9'(sample_total)) ? AW'(col_cnt)
                                                    : AW'(sample_total - NW'(1));
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          if (rem_ge) begin
            rem <= REM_W'(rem_sh - {1'b0, den});
            qsh <= {qsh[DIV_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[REM_W-1:0];
            qsh <= {qsh[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == '0 && !sel_row) begin
            idx <= ({qsh[DIV_W-2:0], rem_ge} >= DIV_W'(sample_total))
                   ? AW'(sample_total - NW'(1)) : AW'({qsh[DIV_W-2:0], rem_ge});
          end
        end
        ST_READ: ;
        ST_SCALE1: begin
          if (gain == 8'd0) acc <= (rdata > disp_min) ? DIV_W'(rdata - disp_min) : '0;
          else              acc <= DIV_W'(rdata) * DIV_W'(gain);
        end
        ST_SCALE2: begin
          if (gain == 8'd0) begin
            if (acc > DIV_W'(pad)) acc <= DIV_W'(pad);
          end else begin
            if (acc > DIV_W'(max_value)) acc <= DIV_W'(max_value);
          end
        end
        ST_SCALE3: begin
          sel_row <= 1'b1;
          zero_fs <= (gain != 8'd0) && (max_value == 16'd0);
          qsh     <= DIV_W'(acc[15:0]) * DIV_W'(plot_height);
          den     <= (gain == 8'd0) ? pad : REM_W'(max_value);
          rem     <= '0;
          div_cnt <= CNT_W'(DIV_W - 1);
        end
        ST_FIN: begin
          result.column       <= col_pos;
          result.span_top     <= top_row;
          result.span_bottom  <= (bot_row > 8'(SCREEN_ROWS - 1)) ? 8'(SCREEN_ROWS - 1)
                                                                 : bot_row;
          result.on_screen    <= (9'(col_pos) < 9'(SCREEN_COLUMNS)) &&
                                 (9'(top_row) < 9'(SCREEN_ROWS));
          result.final_column <= (col_cnt == plot_width - 8'd1);
          done      <= 1'b1;
          prev_row  <= cur_row;
          have_prev <= 1'b1;
          col_cnt   <= col_cnt + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // Hold the result beat clear of new work: the block is idle when it fires.
  `WCP_ASSERT_IMP(a_done_idle, done, !busy, "result beat while busy")
  // Keep bottom of every span on the screen rows.
  `WCP_ASSERT_IMP(a_bot_clip, done, result.span_bottom <= 8'(SCREEN_ROWS - 1), "span bottom not clipped")
  // Advance into work on every accepted load beat.
  `WCP_ASSERT_NXT(a_load_busy, start && !busy && item.action == ACT_LOAD, busy, "load beat dropped")

endmodule
`default_nettype wire

### tb/waveform_column_plotter_test.sv
// Self-checking testbench for the waveform column plotter: loads, draws and spans.
`default_nettype none
module waveform_column_plotter_test;
  import wcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  waveform_column_plotter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state, mirrored from the block's architectural state.
  logic [15:0] pm_store [256];
  int unsigned pm_total, pm_min, pm_max, pm_pad, pm_dmin, pm_col, pm_prev;
  bit          pm_have_prev, pm_loading, pm_ready;
  int unsigned r_xs, r_ys, r_w, r_h, r_maxv, r_gain;

  item_t   stim_queue [$];
  result_t span_queue [$];
  int      error_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Generous fixed ceiling covering the slowest draw beats plus the driver's gaps.
  initial begin
    #(8ns * 600000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int unsigned scale_row(input int unsigned s);
    int unsigned base, d, v;
    base = r_ys + r_h - 1;
    if (r_gain == 0) begin
      d = (s > pm_dmin) ? s - pm_dmin : 0;
      if (d > pm_pad) d = pm_pad;
      return (base - d * r_h / pm_pad) & 8'hFF;
    end
    v = s * r_gain;
    if (v > r_maxv) v = r_maxv;
    if (r_maxv == 0) return r_ys;
    return (base - v * r_h / r_maxv) & 8'hFF;
  endfunction

  // Advance the predictor by one accepted beat; push any expected span.
  task automatic predict_span(input item_t it);
    int unsigned s, rng, pad, half, idx, cur, top, bot, colv;
    result_t r;
    s = it.sample;
    if (it.action == ACT_LOAD) begin
      if (!pm_loading) begin
        // a load after a closed set opens a fresh one
        pm_loading = 1; pm_ready = 0; pm_total = 0; pm_col = 0;
        pm_have_prev = 0; pm_min = s; pm_max = s;
      end
      if (pm_total < 256) begin
        pm_store[pm_total] = 16'(s);
        pm_total++;
        if (s < pm_min) pm_min = s;
        if (s > pm_max) pm_max = s;
      end
      if (it.last_sample) begin
        rng = pm_max - pm_min;
        if (rng == 0) rng = 1;
        pad = rng + rng / 4 + 4;
        half = (pad - rng) / 2;
        pm_pad = pad;
        pm_dmin = (pm_min > half) ? pm_min - half : 0;
        pm_ready = 1; pm_loading = 0; pm_col = 0; pm_have_prev = 0;
      end
      return;
    end
    if (!pm_ready || r_w == 0 || r_h == 0 || pm_total == 0) return;
    if (pm_col >= r_w) return;
    if (pm_total > r_w) begin
      idx = pm_col * pm_total / r_w;
      if (idx >= pm_total) idx = pm_total - 1;
    end else begin
      idx = (pm_col < pm_total) ? pm_col : pm_total - 1;
    end
    if (idx > 255) idx = 255;
    cur = scale_row(pm_store[idx]);
    if (pm_have_prev) begin
      top = (pm_prev < cur) ? pm_prev : cur;
      bot = (pm_prev < cur) ? cur : pm_prev;
    end else begin
      top = cur; bot = cur;
    end
    if (bot > 63) bot = 63;
    colv = (r_xs + pm_col) & 8'hFF;
    r.column = 8'(colv);
    r.span_top = 8'(top);
    r.span_bottom = 8'(bot);
    r.on_screen = (colv < 128 && top < 64);
    r.final_column = (pm_col == r_w - 1);
    span_queue.push_back(r);
    pm_prev = cur; pm_have_prev = 1; pm_col++;
  endtask

  // Driver: bursts of beats with random gaps, changes on the falling edge.
  int burst_left = 0;
  int gap_left = 0;
  logic busy_at_rise = 1'b1;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_rise) begin
      // previous beat was taken at the last rising edge
      if (stim_queue.size() != 0 && burst_left > 0) begin
        item <= stim_queue.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        if (burst_left == 0) gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (stim_queue.size() != 0) begin
        item <= stim_queue.pop_front();
        start <= 1'b1;
        burst_left <= $urandom_range(0, 12);
      end
    end
  end

  // Monitor: sample at the rising edge; accept beats and check spans.
  result_t want;
  always @(posedge clk) begin
    busy_at_rise <= busy;
    if (!rst) begin
      if (start && !busy) predict_span(item);
      if (done) begin
        if (span_queue.size() == 0) begin
          report_mismatch("span with no expectation");
        end else begin
          want = span_queue.pop_front();
          if (result.column !== want.column)
            report_mismatch($sformatf("column %0d want %0d", result.column, want.column));
          if (result.span_top !== want.span_top)
            report_mismatch($sformatf("span_top %0d want %0d",
                                      result.span_top, want.span_top));
          if (result.span_bottom !== want.span_bottom)
            report_mismatch($sformatf("span_bottom %0d want %0d",
                                      result.span_bottom, want.span_bottom));
          if (result.on_screen !== want.on_screen)
            report_mismatch("on_screen flag");
          if (result.final_column !== want.final_column)
            report_mismatch("final_column flag");
        end
      end
    end
  end

  function automatic item_t mk(input action_t a, input int unsigned s, input bit l);
    item_t it;
    it.action = a; it.sample = 16'(s); it.last_sample = l;
    return it;
  endfunction

  // Wait until every queued beat is taken and every span arrived, then drain.
  task automatic settle();
    while (stim_queue.size() != 0 || start || span_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 16'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_X_START:     r_xs = v & 8'hFF;
      REG_Y_START:     r_ys = v & 8'hFF;
      REG_PLOT_WIDTH:  r_w = v & 8'hFF;
      REG_PLOT_HEIGHT: r_h = v & 8'hFF;
      REG_MAX_VALUE:   r_maxv = v & 16'hFFFF;
      default:         r_gain = v & 8'hFF;
    endcase
  endtask

  // One well-formed set of n samples then d draws with random payloads.
  task automatic queue_set(input int n, input int d, input int unsigned lo,
                           input int unsigned hi);
    for (int i = 0; i < n; i++)
      stim_queue.push_back(mk(ACT_LOAD, $urandom_range(lo, hi), i == n - 1));
    for (int i = 0; i < d; i++)
      stim_queue.push_back(mk(ACT_DRAW, $urandom, $urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned lo, hi;
    r_xs = 0; r_ys = 0; r_w = 128; r_h = 64; r_maxv = 4095; r_gain = 0;
    pm_total = 0; pm_min = 0; pm_max = 0; pm_pad = 1; pm_dmin = 0;
    pm_col = 0; pm_prev = 0; pm_have_prev = 0; pm_loading = 0; pm_ready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: draw before any set, extremes, flat set, plot completion.
    write_reg(REG_PLOT_WIDTH, 4);
    stim_queue.push_back(mk(ACT_DRAW, 0, 0));
    stim_queue.push_back(mk(ACT_LOAD, 16'hFFFF, 0));
    stim_queue.push_back(mk(ACT_LOAD, 0, 0));
    stim_queue.push_back(mk(ACT_LOAD, 16'h8000, 1));
    for (int i = 0; i < 6; i++) stim_queue.push_back(mk(ACT_DRAW, 16'hFFFF, 1));
    stim_queue.push_back(mk(ACT_LOAD, 100, 1));   // flat single-sample set
    for (int i = 0; i < 3; i++) stim_queue.push_back(mk(ACT_DRAW, 0, 0));
    settle();
    write_reg(REG_GAIN, 255); write_reg(REG_MAX_VALUE, 0);
    write_reg(REG_X_START, 126); write_reg(REG_Y_START, 255);
    stim_queue.push_back(mk(ACT_LOAD, 7, 0));
    stim_queue.push_back(mk(ACT_LOAD, 1, 1));
    for (int i = 0; i < 4; i++) stim_queue.push_back(mk(ACT_DRAW, 0, 0));
    settle();
    write_reg(REG_PLOT_HEIGHT, 0);
    stim_queue.push_back(mk(ACT_DRAW, 0, 0));
    settle();

    // Random phases across several register settings.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_X_START, ph == 11 ? 255 : $urandom_range(0, 140));
      write_reg(REG_Y_START, ph == 10 ? 255 : ($urandom_range(0, 3) == 0 ?
                                              $urandom_range(0, 255) : $urandom_range(0, 8)));
      write_reg(REG_PLOT_WIDTH, ph == 9 ? 255 : (ph == 8 ? 0 : $urandom_range(1, 24)));
      write_reg(REG_PLOT_HEIGHT, ph == 9 ? 255 : (ph == 7 ? 1 : $urandom_range(0, 80)));
      write_reg(REG_MAX_VALUE, ph == 6 ? 16'hFFFF : $urandom_range(0, 9000));
      write_reg(REG_GAIN, (ph % 2) ? 0 : (ph == 4 ? 255 : $urandom_range(0, 40)));
      for (int k = 0; k < 6; k++) begin
        lo = $urandom; lo = lo & 16'hFFFF;
        hi = lo + $urandom_range(0, 16'hFFFF - lo);
        if (ph == 5 && k == 0) queue_set(260, 6, 0, 16'hFFFF);   // overfill the store
        else queue_set($urandom_range(1, 14), $urandom_range(0, 26), lo, hi);
        if ($urandom_range(0, 4) == 0)
          stim_queue.push_back(mk(action_t'($urandom_range(0, 1)), $urandom, 0));
      end
      settle();
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && span_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
